// ----- sv/rgbhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV pixel converter.
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumW      = 11;  // sector numerator, below 6 * 255
  localparam int unsigned QuotW     = 8;
  localparam int unsigned StepBits  = 2;   // quotient bits per divider stage
  localparam int unsigned DivStages = QuotW / StepBits;

  localparam int unsigned HueNumW = 19;    // N * S + 3d
  localparam int unsigned HueDenW = 11;    // 6d
  localparam int unsigned SatNumW = 17;    // 510d + max
  localparam int unsigned SatDenW = 9;     // 2 * max

  // Front, prep, divider stages, output register.
  localparam int unsigned Latency = 3 + DivStages;

  localparam logic [ChanW-1:0] HueScaleStd  = 8'd180;
  localparam logic [ChanW-1:0] HueScaleByte = 8'd255;

  typedef struct packed {
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] d;
    logic [NumW-1:0]  n;
    logic             zero;
    logic             scale_full;
    logic [ChanW-1:0] alpha;
  } front_t;

  typedef struct packed {
    logic [HueNumW-1:0] hue_num;
    logic [HueDenW-1:0] hue_den;
    logic [SatNumW-1:0] sat_num;
    logic [SatDenW-1:0] sat_den;
  } div_op_t;

  typedef struct packed {
    logic             zero;
    logic             scale_full;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] alpha;
  } side_t;

endpackage

`default_nettype wire

// ----- sv/rgbhsv_front.sv -----
// Front stage: max, min, chroma and hue sector numerator.
`default_nettype none

module rgbhsv_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [rgbhsv_pkg::ChanW-1:0] red_i,
  input  wire logic [rgbhsv_pkg::ChanW-1:0] green_i,
  input  wire logic [rgbhsv_pkg::ChanW-1:0] blue_i,
  input  wire logic [rgbhsv_pkg::ChanW-1:0] alpha_i,
  input  wire logic                         scale_full_i,
  output logic                              valid_o,
  output rgbhsv_pkg::front_t                front_o
);

  logic [rgbhsv_pkg::ChanW-1:0] mx, mn, d;
  logic [rgbhsv_pkg::NumW-1:0]  n;
  rgbhsv_pkg::front_t           front_d, front_q;
  logic                         valid_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    d = mx - mn;

    // Red wins ties, then green.
    if (mx == red_i) begin
      if (green_i >= blue_i) begin
        n = rgbhsv_pkg::NumW'(green_i - blue_i);
      end else begin
        n = rgbhsv_pkg::NumW'({d, 2'b00}) + rgbhsv_pkg::NumW'({d, 1'b0})
            - rgbhsv_pkg::NumW'(blue_i - green_i);
      end
    end else if (mx == green_i) begin
      n = rgbhsv_pkg::NumW'({d, 1'b0}) + rgbhsv_pkg::NumW'(blue_i)
          - rgbhsv_pkg::NumW'(red_i);
    end else begin
      n = rgbhsv_pkg::NumW'({d, 2'b00}) + rgbhsv_pkg::NumW'(red_i)
          - rgbhsv_pkg::NumW'(green_i);
    end

    front_d.mx         = mx;
    front_d.d          = d;
    front_d.n          = n;
    front_d.zero       = (d == '0);   // grey or black: hue and saturation are 0
    front_d.scale_full = scale_full_i;
    front_d.alpha      = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

`default_nettype wire

// ----- sv/rgbhsv_prep.sv -----
// Prep stage: scale the hue numerator and form both divider operands.
`default_nettype none

module rgbhsv_prep (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire rgbhsv_pkg::front_t  front_i,
  output logic                     valid_o,
  output rgbhsv_pkg::div_op_t      op_o,
  output rgbhsv_pkg::side_t        side_o
);

  logic [rgbhsv_pkg::ChanW-1:0] scale;
  rgbhsv_pkg::div_op_t          op_d, op_q;
  rgbhsv_pkg::side_t            side_d, side_q;
  logic                         valid_q;

  always_comb begin
    scale = front_i.scale_full ? rgbhsv_pkg::HueScaleByte : rgbhsv_pkg::HueScaleStd;

    // hue = floor((N*S + 3d) / 6d)
    op_d.hue_num = rgbhsv_pkg::HueNumW'(front_i.n) * rgbhsv_pkg::HueNumW'(scale)
                 + rgbhsv_pkg::HueNumW'({front_i.d, 1'b0})
                 + rgbhsv_pkg::HueNumW'(front_i.d);
    op_d.hue_den = rgbhsv_pkg::HueDenW'({front_i.d, 2'b00})
                 + rgbhsv_pkg::HueDenW'({front_i.d, 1'b0});

    // sat = floor((510d + max) / 2max)
    op_d.sat_num = rgbhsv_pkg::SatNumW'({front_i.d, 9'b0})
                 - rgbhsv_pkg::SatNumW'({front_i.d, 1'b0})
                 + rgbhsv_pkg::SatNumW'(front_i.mx);
    op_d.sat_den = {front_i.mx, 1'b0};

    side_d.zero       = front_i.zero;
    side_d.scale_full = front_i.scale_full;
    side_d.mx         = front_i.mx;
    side_d.alpha      = front_i.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ----- sv/rgbhsv_div.sv -----
// Pipelined restoring divider, a few quotient bits per stage.
`default_nettype none

module rgbhsv_div #(
  parameter int unsigned NUM_W = rgbhsv_pkg::HueNumW,
  parameter int unsigned DEN_W = rgbhsv_pkg::HueDenW
) (
  input  wire logic                          clk_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [DEN_W-1:0]              den_i,
  output logic      [rgbhsv_pkg::QuotW-1:0]  quot_o
);

  localparam int unsigned QW     = rgbhsv_pkg::QuotW;
  localparam int unsigned SB     = rgbhsv_pkg::StepBits;
  localparam int unsigned STAGES = rgbhsv_pkg::DivStages;
  localparam int unsigned SHW    = DEN_W + QW - 1;
  localparam int unsigned W      = (NUM_W > SHW) ? NUM_W : SHW;

  // Quotient is known to fit QW bits: num < den * 2**QW.
  logic [W-1:0]     rem_q  [STAGES];
  logic [DEN_W-1:0] den_q  [STAGES];
  logic [QW-1:0]    quot_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [W-1:0]     rem_in, rem_out;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    quot_in, quot_out;

    if (s == 0) begin : g_first
      assign rem_in  = W'(num_i);
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    always_comb begin
      logic [W-1:0] trial;
      rem_out  = rem_in;
      quot_out = quot_in;
      for (int k = 0; k < SB; k++) begin
        trial = W'(den_in) << (QW - 1 - s * SB - k);
        if (rem_out >= trial) begin
          rem_out = rem_out - trial;
          quot_out[QW - 1 - s * SB - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_out;
      den_q[s]  <= den_in;
      quot_q[s] <= quot_out;
    end
  end

  assign quot_o = quot_q[STAGES-1];

endmodule

`default_nettype wire

// ----- sv/rgb_to_hsv_pixel_top.sv -----
// Top level of the RGB to HSV pixel converter.
// From the start beat, a pixel passes the front, prep, divider and output registers to the result strobe.
// Throughput: one pixel per cycle; busy stays low, so start may be held high.
// The hue and saturation divides run in a 4-stage restoring divider, 2 bits per stage.
// Reset (async, active low) clears all valid bits and the hue scale bit (scale 180).
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module rgb_to_hsv_pixel_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic [7:0] alpha_i,
  input  wire logic       hue_scale_full_byte_we_i,
  input  wire logic       hue_scale_full_byte_i,
  output logic            result_valid_o,
  output logic      [7:0] hue_o,
  output logic      [7:0] saturation_o,
  output logic      [7:0] brightness_o,
  output logic      [7:0] alpha_out_o
);

  localparam int unsigned STAGES = rgbhsv_pkg::DivStages;

  // Config register: hue full scale 180 (0) or 255 (1).
  logic scale_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_full_q <= 1'b0;
    end else if (hue_scale_full_byte_we_i) begin
      scale_full_q <= hue_scale_full_byte_i;
    end
  end

  // Never stalls: a pixel enters on every start beat.
  assign busy = 1'b0;

  // Stage 1: max, min, chroma, sector numerator.
  logic               front_valid;
  rgbhsv_pkg::front_t front;

  rgbhsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .scale_full_i (scale_full_q),
    .valid_o      (front_valid),
    .front_o      (front)
  );

  // Stage 2: scale the numerator, build dividends and divisors.
  logic                prep_valid;
  rgbhsv_pkg::div_op_t op;
  rgbhsv_pkg::side_t   side;

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (prep_valid),
    .op_o    (op),
    .side_o  (side)
  );

  // Stages 3 to 6: both divides side by side.
  logic [rgbhsv_pkg::QuotW-1:0] hue_quot, sat_quot;

  rgbhsv_div #(
    .NUM_W (rgbhsv_pkg::HueNumW),
    .DEN_W (rgbhsv_pkg::HueDenW)
  ) u_hue_div (
    .clk_i  (clk_i),
    .num_i  (op.hue_num),
    .den_i  (op.hue_den),
    .quot_o (hue_quot)
  );

  rgbhsv_div #(
    .NUM_W (rgbhsv_pkg::SatNumW),
    .DEN_W (rgbhsv_pkg::SatDenW)
  ) u_sat_div (
    .clk_i  (clk_i),
    .num_i  (op.sat_num),
    .den_i  (op.sat_den),
    .quot_o (sat_quot)
  );

  // Carry valid and sideband alongside the divider stages.
  logic              side_valid_q [STAGES];
  rgbhsv_pkg::side_t side_q       [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        side_valid_q[s] <= 1'b0;
      end
    end else begin
      side_valid_q[0] <= prep_valid;
      for (int s = 1; s < STAGES; s++) begin
        side_valid_q[s] <= side_valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side;
    for (int s = 1; s < STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // Stage 7: wrap full-scale hue, zero grey and black pixels, drive the beat.
  rgbhsv_pkg::side_t            last;
  logic [rgbhsv_pkg::ChanW-1:0] hue_scale;
  logic [7:0]                   hue_d, sat_d;
  logic                         valid_q, out_full_q;
  logic [7:0]                   hue_q, sat_q, bright_q, alpha_q;

  assign last = side_q[STAGES-1];

  always_comb begin
    hue_scale = last.scale_full ? rgbhsv_pkg::HueScaleByte : rgbhsv_pkg::HueScaleStd;
    hue_d     = (hue_quot >= hue_scale) ? 8'd0 : hue_quot;
    sat_d     = sat_quot;
    if (last.zero) begin
      hue_d = 8'd0;
      sat_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_valid_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q      <= hue_d;
    sat_q      <= sat_d;
    bright_q   <= last.mx;
    alpha_q    <= last.alpha;
    out_full_q <= last.scale_full;
  end

  assign result_valid_o = valid_q;
  assign hue_o          = hue_q;
  assign saturation_o   = sat_q;
  assign brightness_o   = bright_q;
  assign alpha_out_o    = alpha_q;

  // Every accepted pixel raises the result strobe once it has passed the pipeline.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rgbhsv_pkg::Latency) result_valid_o)
    else $error("result strobe missing after accepted pixel");

  // With the standard scale chosen when the pixel went in, hue stays below 180.
  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_full_q) |-> (hue_o < rgbhsv_pkg::HueScaleStd))
    else $error("hue at or above 180 with standard scale");

  // A black pixel yields zero hue and saturation.
  a_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && brightness_o == 8'd0) |-> (hue_o == 8'd0 && saturation_o == 8'd0))
    else $error("nonzero hue or saturation for black pixel");

  // Nothing leaves the pipeline that did not enter it.
  a_no_ghost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(side_valid_q[STAGES-1]))
    else $error("result strobe without a pixel in flight");

endmodule

`default_nettype wire
